### rtl/mppc_pkg.sv
// Shared types, constants and helpers for the multi-plane polygon clipper.
// Used by mppc_cell and multi_plane_polygon_clip_core; no dependencies.
`default_nettype none

package mppc_pkg;

    localparam int COORD_BITS = 16;
    localparam int NUM_W      = 16;                 // normal / offset field width
    localparam int OFF_SHIFT  = 14;                 // offset Q8.8 -> distance scale
    localparam int DIST_W     = COORD_BITS + 18;    // exact signed distance
    localparam int ALPHA_W    = 16;
    localparam int PLANE_W    = 48;
    localparam int PCOUNT_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIV_IT_W   = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PLANE_COUNT = 3'd0;
    localparam t_cfg_idx CFG_PLANE_ZERO  = 3'd1;
    localparam t_cfg_idx CFG_PLANE_ONE   = 3'd2;
    localparam t_cfg_idx CFG_PLANE_TWO   = 3'd3;
    localparam t_cfg_idx CFG_PLANE_THREE = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vert_x;
        logic signed [COORD_BITS-1:0] vert_y;
        logic                         final_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         is_vertex;
        logic                         end_of_polygon;
        logic                         too_many;
    } t_out_item;

    // Token handed from cell to cell: a vertex, or the end-of-polygon sweep.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         fin;
    } t_tok;

    typedef enum logic [3:0] {
        C_IDLE, C_PASS, C_D1, C_D2, C_DECIDE, C_DIV, C_MX, C_MY,
        C_EMIT_X, C_KEEP, C_EMIT_V, C_FIN_FWD
    } t_cell_st;

    typedef enum logic [2:0] {
        T_IDLE, T_VTX, T_FIN, T_WAIT_FIN, T_DRAIN
    } t_top_st;

    function automatic logic f_opposite(input logic signed [DIST_W-1:0] a,
                                        input logic signed [DIST_W-1:0] b);
        logic a_neg, a_pos, b_neg, b_pos;
        a_neg = a[DIST_W-1];
        b_neg = b[DIST_W-1];
        a_pos = !a_neg && (a != '0);
        b_pos = !b_neg && (b != '0);
        return (a_neg && b_pos) || (a_pos && b_neg);
    endfunction

    function automatic logic [DIST_W-1:0] f_abs(input logic signed [DIST_W-1:0] a);
        logic [DIST_W-1:0] r;
        r = a[DIST_W-1] ? DIST_W'(-a) : DIST_W'(a);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/mppc_cell.sv
// One clipping cell: holds the per-plane state, computes distances, divides
// for alpha, interpolates crossings and hands tokens to the next cell.
// Depends on mppc_pkg.
`default_nettype none

module mppc_cell #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic [mppc_pkg::PLANE_W-1:0]     i_plane,
    input  wire logic                             i_in_valid,
    input  wire mppc_pkg::t_tok                   i_in_tok,
    output logic                                  o_in_ready,
    input  wire logic                             i_down_idle,
    output logic                                  o_out_valid,
    output mppc_pkg::t_tok                        o_out_tok,
    input  wire logic                             i_out_ready,
    output logic                                  o_idle,
    output logic                                  o_ovf_evt
);

    localparam int CW  = mppc_pkg::COORD_BITS;
    localparam int DW  = mppc_pkg::DIST_W;
    localparam int NW  = mppc_pkg::NUM_W;
    localparam int AW  = mppc_pkg::ALPHA_W;
    localparam int CNT_W = $clog2(MAX_VERTICES + 2);

    mppc_pkg::t_cell_st r_st, n_st;

    logic signed [CW-1:0] r_x, r_y, r_fx, r_fy, r_px, r_py;
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic                 r_fin;
    logic signed [DW-1:0] r_fd, r_pd, r_acc, r_d;
    logic [DW:0]          r_rem, r_den;
    logic [AW-1:0]        r_q;
    logic [mppc_pkg::DIV_IT_W-1:0] r_it;
    logic                 r_seen;
    logic [CNT_W-1:0]     r_cnt;

    logic signed [NW-1:0]    w_nx, w_ny, w_off;
    logic signed [NW+CW-1:0] w_mul_a, w_mul_b;
    logic signed [DW-1:0]    w_off_ext, w_d;
    logic [DW+1:0]           w_rem2;
    logic                    w_ge;
    logic signed [CW:0]      w_diff;
    logic signed [2*CW+1:0]  w_prod;
    logic signed [CW-1:0]    w_lerp;
    logic                    in_acc, out_acc;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic                    w_fin_cross, w_vtx_cross;

    assign w_nx  = i_plane[47:32];
    assign w_ny  = i_plane[31:16];
    assign w_off = i_plane[15:0];

    assign w_mul_a   = w_nx * r_x;
    assign w_mul_b   = w_ny * r_y;
    assign w_off_ext = {{(DW-NW-mppc_pkg::OFF_SHIFT){w_off[NW-1]}}, w_off,
                        {mppc_pkg::OFF_SHIFT{1'b0}}};
    assign w_d       = r_acc + DW'(w_mul_b) + w_off_ext;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    // Crossing = B + floor(alpha * (A - B) / 2^16).
    assign w_diff = (r_st == mppc_pkg::C_MX) ? ((CW+1)'(r_ax) - (CW+1)'(r_bx))
                                             : ((CW+1)'(r_ay) - (CW+1)'(r_by));
    assign w_prod = $signed({1'b0, r_q}) * w_diff;
    assign w_lerp = ((r_st == mppc_pkg::C_MX) ? r_bx : r_by) + w_prod[CW+AW-1:AW];

    assign w_fin_cross = r_seen && mppc_pkg::f_opposite(r_pd, r_fd);
    assign w_vtx_cross = r_seen && mppc_pkg::f_opposite(r_pd, r_d);

    assign o_idle     = (r_st == mppc_pkg::C_IDLE);
    assign o_in_ready = o_idle && i_down_idle;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;

    assign w_cnt_inc = (r_cnt <= CNT_W'(MAX_VERTICES)) ? r_cnt + 1'b1 : r_cnt;
    assign o_ovf_evt = out_acc && ((r_st == mppc_pkg::C_EMIT_X) ||
                       (r_st == mppc_pkg::C_EMIT_V)) && (w_cnt_inc > CNT_W'(MAX_VERTICES));

    always_comb begin
        n_st        = r_st;
        o_out_valid = 1'b0;
        o_out_tok   = '{x: r_x, y: r_y, fin: r_fin};
        case (r_st)
            mppc_pkg::C_IDLE: begin
                if (in_acc) begin
                    if (!i_en) begin
                        n_st = mppc_pkg::C_PASS;
                    end else if (i_in_tok.fin) begin
                        n_st = w_fin_cross ? mppc_pkg::C_DIV : mppc_pkg::C_FIN_FWD;
                    end else begin
                        n_st = mppc_pkg::C_D1;
                    end
                end
            end
            mppc_pkg::C_PASS: begin
                o_out_valid = 1'b1;
                if (out_acc) n_st = mppc_pkg::C_IDLE;
            end
            mppc_pkg::C_D1:     n_st = mppc_pkg::C_D2;
            mppc_pkg::C_D2:     n_st = mppc_pkg::C_DECIDE;
            mppc_pkg::C_DECIDE: n_st = w_vtx_cross ? mppc_pkg::C_DIV : mppc_pkg::C_KEEP;
            mppc_pkg::C_DIV: begin
                if (r_it == '1) n_st = mppc_pkg::C_MX;
            end
            mppc_pkg::C_MX:     n_st = mppc_pkg::C_MY;
            mppc_pkg::C_MY:     n_st = mppc_pkg::C_EMIT_X;
            mppc_pkg::C_EMIT_X: begin
                o_out_valid = 1'b1;
                o_out_tok   = '{x: r_cx, y: r_cy, fin: 1'b0};
                if (out_acc) n_st = r_fin ? mppc_pkg::C_FIN_FWD : mppc_pkg::C_KEEP;
            end
            mppc_pkg::C_KEEP: begin
                n_st = r_d[DW-1] ? mppc_pkg::C_IDLE : mppc_pkg::C_EMIT_V;
            end
            mppc_pkg::C_EMIT_V: begin
                o_out_valid = 1'b1;
                o_out_tok   = '{x: r_x, y: r_y, fin: 1'b0};
                if (out_acc) n_st = mppc_pkg::C_IDLE;
            end
            mppc_pkg::C_FIN_FWD: begin
                o_out_valid = 1'b1;
                o_out_tok   = '{x: '0, y: '0, fin: 1'b1};
                if (out_acc) n_st = mppc_pkg::C_IDLE;
            end
            default: n_st = mppc_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= mppc_pkg::C_IDLE;
            r_seen <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == mppc_pkg::C_DECIDE) r_seen <= 1'b1;
            if (out_acc && ((r_st == mppc_pkg::C_EMIT_X) || (r_st == mppc_pkg::C_EMIT_V)))
                r_cnt <= w_cnt_inc;
            // end of polygon: drop the stage state
            if (out_acc && (r_st == mppc_pkg::C_FIN_FWD)) begin
                r_seen <= 1'b0;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            mppc_pkg::C_IDLE: begin
                if (in_acc) begin
                    r_x   <= i_in_tok.x;
                    r_y   <= i_in_tok.y;
                    r_fin <= i_in_tok.fin;
                    // closing edge: prev -> first
                    r_ax  <= r_px;
                    r_ay  <= r_py;
                    r_bx  <= r_fx;
                    r_by  <= r_fy;
                    r_rem <= {1'b0, mppc_pkg::f_abs(r_fd)};
                    r_den <= {1'b0, mppc_pkg::f_abs(r_pd)} + {1'b0, mppc_pkg::f_abs(r_fd)};
                    r_it  <= '0;
                end
            end
            mppc_pkg::C_D1: r_acc <= DW'(w_mul_a);
            mppc_pkg::C_D2: r_d   <= w_d;
            mppc_pkg::C_DECIDE: begin
                if (!r_seen) begin
                    r_fx <= r_x;
                    r_fy <= r_y;
                    r_fd <= r_d;
                end
                r_ax  <= r_px;
                r_ay  <= r_py;
                r_bx  <= r_x;
                r_by  <= r_y;
                r_rem <= {1'b0, mppc_pkg::f_abs(r_d)};
                r_den <= {1'b0, mppc_pkg::f_abs(r_pd)} + {1'b0, mppc_pkg::f_abs(r_d)};
                r_it  <= '0;
            end
            mppc_pkg::C_DIV: begin
                r_rem <= w_ge ? (DW+1)'(w_rem2 - {1'b0, r_den}) : (DW+1)'(w_rem2);
                r_q   <= {r_q[AW-2:0], w_ge};
                r_it  <= r_it + 1'b1;
            end
            mppc_pkg::C_MX: r_cx <= w_lerp;
            mppc_pkg::C_MY: r_cy <= w_lerp;
            mppc_pkg::C_KEEP: begin
                r_px <= r_x;
                r_py <= r_y;
                r_pd <= r_d;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/multi_plane_polygon_clip_core.sv
// Top level of the multi-plane polygon clipper: configuration registers,
// input sequencing, the row of mppc_cell stages and the result buffer.
// Depends on mppc_pkg and mppc_cell.
//
//   channel | signals                            | direction | handshake
//   --------+------------------------------------+-----------+-----------
//   in      | i_in_valid/o_in_ready, i_in_item   | into core | valid/ready
//   out     | o_out_valid/i_out_ready, o_out_item| out of core| valid/ready
//   cfg     | i_cfg_we, i_cfg_idx, i_cfg_data    | into core | write strobe
//
// One item is taken at a time. An active cell runs two distance steps,
// decide and keep on every vertex, plus a hand-off for a kept one; a
// crossing adds a 16-step alpha divider, two interpolation multiplies and
// a hand-off. Tokens run depth-first through the row, so an item's time
// is the input sequencing plus the sum of that cell work.
// A final vertex adds the closing sweep through every cell.
// Reset is synchronous, active low, and clears control state and configuration registers.
// A stalled output holds one result in the output register and one pending.
`default_nettype none

module multi_plane_polygon_clip_core #(
    parameter int MAX_PLANES   = 4,
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire mppc_pkg::t_in_item                 i_in_item,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output mppc_pkg::t_out_item                     o_out_item,
    input  wire logic                               i_cfg_we,
    input  wire logic [mppc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [mppc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PW = mppc_pkg::PCOUNT_W;

    mppc_pkg::t_top_st r_st, n_st;

    logic [PW-1:0]                r_pcount;
    logic [mppc_pkg::PLANE_W-1:0] r_plane [4];
    mppc_pkg::t_in_item           r_in;
    mppc_pkg::t_out_item          r_pend, r_out;
    logic                         r_pend_v, r_out_v, r_ovf;

    logic                  w_v   [MAX_PLANES+1];
    logic                  w_r   [MAX_PLANES+1];
    mppc_pkg::t_tok        w_tok [MAX_PLANES+1];
    logic [MAX_PLANES-1:0] w_idle, w_evt, w_down;
    logic [PW-1:0]         w_active;
    logic                  all_idle, can_move, in_acc, sink_v_acc, sink_f_acc, any_evt;
    logic                  drain_move;

    // Plane counts above the row length act as the full row.
    assign w_active = (r_pcount > PW'(MAX_PLANES)) ? PW'(MAX_PLANES) : r_pcount;
    assign all_idle = &w_idle;
    assign any_evt  = |w_evt;
    assign can_move = !r_out_v || i_out_ready;

    assign o_in_ready  = (r_st == mppc_pkg::T_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    // Feed the head of the row: the vertex, then the closing sweep if final.
    assign w_v[0]   = (r_st == mppc_pkg::T_VTX) || (r_st == mppc_pkg::T_FIN);
    assign w_tok[0] = (r_st == mppc_pkg::T_VTX) ?
                      '{x: r_in.vert_x, y: r_in.vert_y, fin: 1'b0} :
                      '{x: '0, y: '0, fin: 1'b1};

    genvar g;
    generate
        for (g = 0; g < MAX_PLANES; g++) begin : g_cell
            if (g == MAX_PLANES - 1) begin : g_last
                assign w_down[g] = 1'b1;
            end else begin : g_mid
                assign w_down[g] = w_idle[g+1] & w_down[g+1];
            end
            mppc_cell #(
                .MAX_VERTICES (MAX_VERTICES)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (PW'(g) < w_active),
                .i_plane     (r_plane[g]),
                .i_in_valid  (w_v[g]),
                .i_in_tok    (w_tok[g]),
                .o_in_ready  (w_r[g]),
                .i_down_idle (w_down[g]),
                .o_out_valid (w_v[g+1]),
                .o_out_tok   (w_tok[g+1]),
                .i_out_ready (w_r[g+1]),
                .o_idle      (w_idle[g]),
                .o_ovf_evt   (w_evt[g])
            );
        end
    endgenerate

    // Tail of the row: a vertex goes to the pending slot, the sweep closes the item.
    assign w_r[MAX_PLANES] = w_tok[MAX_PLANES].fin ? can_move : (!r_pend_v || can_move);
    assign sink_v_acc = w_v[MAX_PLANES] && w_r[MAX_PLANES] && !w_tok[MAX_PLANES].fin;
    assign sink_f_acc = w_v[MAX_PLANES] && w_r[MAX_PLANES] && w_tok[MAX_PLANES].fin;
    assign drain_move = (r_st == mppc_pkg::T_DRAIN) && all_idle && r_pend_v && can_move;

    always_comb begin
        n_st = r_st;
        case (r_st)
            mppc_pkg::T_IDLE:     if (in_acc) n_st = mppc_pkg::T_VTX;
            mppc_pkg::T_VTX: begin
                if (w_r[0]) n_st = r_in.final_vertex ? mppc_pkg::T_FIN : mppc_pkg::T_DRAIN;
            end
            mppc_pkg::T_FIN:      if (w_r[0]) n_st = mppc_pkg::T_WAIT_FIN;
            mppc_pkg::T_WAIT_FIN: if (sink_f_acc) n_st = mppc_pkg::T_IDLE;
            mppc_pkg::T_DRAIN: begin
                if (all_idle && (!r_pend_v || can_move)) n_st = mppc_pkg::T_IDLE;
            end
            default: n_st = mppc_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= mppc_pkg::T_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= '0;
            for (int k = 0; k < 4; k++) r_plane[k] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mppc_pkg::CFG_PLANE_COUNT: r_pcount   <= i_cfg_data[PW-1:0];
                mppc_pkg::CFG_PLANE_ZERO:  r_plane[0] <= i_cfg_data;
                mppc_pkg::CFG_PLANE_ONE:   r_plane[1] <= i_cfg_data;
                mppc_pkg::CFG_PLANE_TWO:   r_plane[2] <= i_cfg_data;
                mppc_pkg::CFG_PLANE_THREE: r_plane[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_in <= i_in_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_out_ready) r_out_v <= 1'b0;
            if (any_evt) r_ovf <= 1'b1;
            if (sink_v_acc) begin
                // advance the held result; the new one waits to learn if it is last
                if (r_pend_v) begin
                    r_out   <= r_pend;
                    r_out_v <= 1'b1;
                end
                r_pend   <= '{out_x: w_tok[MAX_PLANES].x, out_y: w_tok[MAX_PLANES].y,
                              is_vertex: 1'b1, end_of_polygon: 1'b0,
                              too_many: r_ovf || any_evt};
                r_pend_v <= 1'b1;
            end
            if (sink_f_acc) begin
                if (r_pend_v) begin
                    r_out <= '{out_x: r_pend.out_x, out_y: r_pend.out_y, is_vertex: 1'b1,
                               end_of_polygon: 1'b1, too_many: r_pend.too_many};
                end else begin
                    // empty polygon: emit the end marker
                    r_out <= '{out_x: '0, out_y: '0, is_vertex: 1'b0,
                               end_of_polygon: 1'b1, too_many: r_ovf};
                end
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
                r_ovf    <= 1'b0;
            end
            if (drain_move) begin
                r_out    <= r_pend;
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == mppc_pkg::T_IDLE) |-> !r_pend_v)
        else $error("pending result left over at item boundary");
    a_in_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> all_idle)
        else $error("item accepted while the cell row is busy");
    a_fin_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sink_f_acc |-> (r_st == mppc_pkg::T_WAIT_FIN))
        else $error("end sweep reached the tail outside its wait state");
    a_ovf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sink_f_acc |=> !r_ovf)
        else $error("overflow flag survived the end of polygon");
    a_one_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(drain_move && (sink_v_acc || sink_f_acc)))
        else $error("drain and tail write the output in the same cycle");
`endif

endmodule

`default_nettype wire

### test/clip_checker.sv
// Watches the channels of the polygon clipper, predicts its results and compares them.
// Depends on mppc_pkg for the item types and register indexes.
`timescale 1ns / 100ps

module clip_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  mppc_pkg::t_in_item                 i_in_item,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  mppc_pkg::t_out_item                i_out_item,
    input  logic                               i_cfg_we,
    input  logic [mppc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mppc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam int NPLANES = 4;
    localparam int VLIMIT  = 64;
    localparam int RES_CAP = 31;

    typedef struct {
        int x;
        int y;
        bit ovf;
    } t_pt;

    mppc_pkg::t_out_item clipped_q[$];
    t_pt       cur_pts[$];
    t_pt       nxt_pts[$];

    logic [2:0]  num_planes;
    logic [47:0] plane_word [NPLANES];
    int          first_x [NPLANES], first_y [NPLANES];
    int          prev_x [NPLANES], prev_y [NPLANES];
    longint      first_d [NPLANES], prev_d [NPLANES];
    bit          started [NPLANES];
    int          emitted [NPLANES];
    bit          ovf_sticky;
    bit          stage_run;

    assign o_pending = clipped_q.size();

    function automatic longint plane_dist(int s, int x, int y);
        longint nx, ny, off;
        nx  = longint'($signed(plane_word[s][47:32]));
        ny  = longint'($signed(plane_word[s][31:16]));
        off = longint'($signed(plane_word[s][15:0]));
        return off * 16384 + nx * x + ny * y;
    endfunction

    function automatic bit crosses(longint a, longint b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // Crossing of edge A->B, alpha weighting A; sum floored toward minus infinity.
    function automatic int crossing(longint da, longint db, int a, int b);
        longint na, nb, al;
        na = da < 0 ? -da : da;
        nb = db < 0 ? -db : db;
        al = (na + nb == 0) ? 0 : (nb << 16) / (na + nb);
        return int'((al * a + (65536 - al) * b) >>> 16);
    endfunction

    function automatic void count_emit(int s);
        if (emitted[s] <= VLIMIT) emitted[s]++;
        if (emitted[s] > VLIMIT) begin
            stage_run  = 1;
            ovf_sticky = 1;
        end
    endfunction

    function automatic void push_pt(int x, int y);
        t_pt p;
        p.x = x; p.y = y; p.ovf = stage_run;
        nxt_pts.push_back(p);
    endfunction

    function automatic void clip_vertex(int s, t_pt p);
        longint d;
        stage_run |= p.ovf;
        d = plane_dist(s, p.x, p.y);
        if (!started[s]) begin
            first_x[s] = p.x; first_y[s] = p.y; first_d[s] = d;
            started[s] = 1;
        end else if (crosses(prev_d[s], d)) begin
            count_emit(s);
            push_pt(crossing(prev_d[s], d, prev_x[s], p.x),
                    crossing(prev_d[s], d, prev_y[s], p.y));
        end
        if (d >= 0) begin
            count_emit(s);
            push_pt(p.x, p.y);
        end
        prev_x[s] = p.x; prev_y[s] = p.y; prev_d[s] = d;
    endfunction

    function automatic void close_stage(int s);
        if (started[s] && crosses(prev_d[s], first_d[s])) begin
            count_emit(s);
            push_pt(crossing(prev_d[s], first_d[s], prev_x[s], first_x[s]),
                    crossing(prev_d[s], first_d[s], prev_y[s], first_y[s]));
        end
        started[s] = 0;
        emitted[s] = 0;
    endfunction

    // Run one vertex through every active stage in turn; each stage sees the
    // whole output of the one before, in order.
    function automatic void predict_clip(mppc_pkg::t_in_item it);
        int        act;
        int        n;
        t_pt       p;
        mppc_pkg::t_out_item r;
        act = (num_planes > NPLANES) ? NPLANES : int'(num_planes);
        cur_pts.delete();
        p.x = it.vert_x; p.y = it.vert_y; p.ovf = ovf_sticky;
        cur_pts.push_back(p);
        for (int s = 0; s < act; s++) begin
            nxt_pts.delete();
            stage_run = 0;
            foreach (cur_pts[k]) clip_vertex(s, cur_pts[k]);
            if (it.final_vertex) close_stage(s);
            cur_pts = nxt_pts;
        end
        n = 0;
        foreach (cur_pts[k]) begin
            if (n < RES_CAP) begin
                r.out_x          = cur_pts[k].x[15:0];
                r.out_y          = cur_pts[k].y[15:0];
                r.is_vertex      = 1;
                r.end_of_polygon = 0;
                r.too_many       = cur_pts[k].ovf;
                clipped_q.push_back(r);
                n++;
            end
        end
        if (it.final_vertex) begin
            if (n == 0) begin
                r = '0;
                r.too_many = ovf_sticky;
                clipped_q.push_back(r);
            end
            clipped_q[$].end_of_polygon = 1;
            ovf_sticky = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        mppc_pkg::t_out_item want;
        if (!i_rst_n) begin
            num_planes = '0;
            ovf_sticky = 0;
            for (int s = 0; s < NPLANES; s++) begin
                plane_word[s] = '0;
                first_x[s] = 0; first_y[s] = 0; prev_x[s] = 0; prev_y[s] = 0;
                first_d[s] = 0; prev_d[s] = 0; started[s] = 0; emitted[s] = 0;
            end
            clipped_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mppc_pkg::CFG_PLANE_COUNT: num_planes    = i_cfg_data[2:0];
                    mppc_pkg::CFG_PLANE_ZERO:  plane_word[0] = i_cfg_data[47:0];
                    mppc_pkg::CFG_PLANE_ONE:   plane_word[1] = i_cfg_data[47:0];
                    mppc_pkg::CFG_PLANE_TWO:   plane_word[2] = i_cfg_data[47:0];
                    mppc_pkg::CFG_PLANE_THREE: plane_word[3] = i_cfg_data[47:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (clipped_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %p", i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = clipped_q.pop_front();
                    if (want !== i_out_item) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, i_out_item);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // Predict after the output compare so same-edge results stay in order.
            if (i_in_valid && i_in_ready) predict_clip(i_in_item);
        end
    end

endmodule

### test/testbench.sv
// Top of the polygon clipper testbench: clock, reset, stimulus and verdict.
// Depends on mppc_pkg, multi_plane_polygon_clip_core and clip_checker.
`timescale 1ns / 100ps

module testbench;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             in_valid;
    logic                             in_ready;
    mppc_pkg::t_in_item               in_item;
    logic                             out_valid;
    logic                             out_ready;
    mppc_pkg::t_out_item              out_item;
    logic                             cfg_we;
    logic [mppc_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [mppc_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                               fail_count;
    int                               pending;
    int                               n_sent;     // input items sent so far
    bit                               quiet;      // stretch with no idling on either side

    multi_plane_polygon_clip_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    clip_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int draw_gap();
        if (quiet) return 0;
        return $urandom_range(0, 14);
    endfunction

    // Pack a plane: normal x, normal y (Q1.14) and offset (Q8.8).
    function automatic logic [47:0] plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] off);
        return {nx, ny, off};
    endfunction

    // Hold valid high with a fixed payload until the item is accepted.
    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic fin);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1;
        in_item.vert_x = x;
        in_item.vert_y = y;
        in_item.final_vertex = fin;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        in_valid = 0;
        n_sent++;
    endtask

    // Wait for every expected result, then give the stages time to go idle.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(mppc_pkg::t_cfg_idx idx, logic [47:0] val);
        cfg_we = 1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 0;
    endtask

    task automatic set_planes(logic [2:0] cnt, logic [47:0] p0, logic [47:0] p1,
                              logic [47:0] p2, logic [47:0] p3);
        drain();
        write_reg(mppc_pkg::CFG_PLANE_COUNT, 48'(cnt));
        write_reg(mppc_pkg::CFG_PLANE_ZERO, p0);
        write_reg(mppc_pkg::CFG_PLANE_ONE, p1);
        write_reg(mppc_pkg::CFG_PLANE_TWO, p2);
        write_reg(mppc_pkg::CFG_PLANE_THREE, p3);
    endtask

    // Square with corners lo and hi, counterclockwise, closed on the last vertex.
    task automatic send_square(logic [15:0] lo, logic [15:0] hi);
        send_vertex(lo, lo, 0);
        send_vertex(hi, lo, 0);
        send_vertex(hi, hi, 0);
        send_vertex(lo, hi, 1);
    endtask

    function automatic logic [15:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        return 16'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(0, 4))
            0: return 16'h4000;
            1: return 16'hc000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [47:0] rand_plane();
        if ($urandom_range(0, 7) == 0) return {16'($urandom()), 32'($urandom())};
        return plane(rand_normal(), rand_normal(), 16'($signed($urandom_range(0, 4096)) - 2048));
    endfunction

    // Output side: stall a drawn number of cycles before each result.
    initial begin
        int gap;
        out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = draw_gap();
            if (gap > 0) begin
                out_ready = 0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready = 1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    initial begin
        int nverts;
        quiet    = 0;
        n_sent   = 0;
        in_valid = 0;
        in_item  = '0;
        cfg_we   = 0;
        cfg_idx  = '0;
        cfg_data = '0;
        i_rst_n  = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: pass-through with no planes, then extremes of coordinates.
        send_vertex(16'h8000, 16'h7fff, 0);
        send_vertex(16'h7fff, 16'h8000, 0);
        send_vertex(16'hffff, 16'h0000, 1);
        // Half-plane x >= 0 cutting a square straddling the axis.
        set_planes(3'd1, plane(16'h4000, 16'h0000, 16'h0000), '0, '0, '0);
        send_square(16'hfc00, 16'h0400);
        // Whole polygon outside: only the end marker comes back.
        send_square(16'hf000, 16'hf800);
        // Single vertex polygon, kept and dropped.
        send_vertex(16'h0100, 16'h0100, 1);
        send_vertex(16'hff00, 16'h0100, 1);
        // Four planes forming a box, extreme corners clipped on every side.
        set_planes(3'd4, plane(16'h4000, 16'h0000, 16'h0200),
                   plane(16'hc000, 16'h0000, 16'h0200),
                   plane(16'h0000, 16'h4000, 16'h0200),
                   plane(16'h0000, 16'hc000, 16'h0200));
        send_square(16'h8000, 16'h7fff);
        // Count above the plane limit acts as four; all-ones planes.
        set_planes(3'd7, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
                   plane(16'h7fff, 16'h8000, 16'h7fff), plane(16'h8000, 16'h7fff, 16'h8000));
        send_square(16'hfe00, 16'h0300);

        // Too many vertices: a stage that keeps everything, fed a long polygon.
        set_planes(3'd1, plane(16'h0000, 16'h0000, 16'h0100), '0, '0, '0);
        for (int k = 0; k < 70; k++) send_vertex(rand_coord(), rand_coord(), k == 69);

        // Random polygons, with a new plane setup every few polygons.
        while (n_sent < 110) begin
            if ($urandom_range(0, 2) == 0)
                set_planes(3'($urandom_range(0, 7)), rand_plane(), rand_plane(),
                           rand_plane(), rand_plane());
            if ($urandom_range(0, 5) == 0) quiet = !quiet;
            nverts = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(3, 8);
            for (int k = 0; k < nverts; k++) begin
                send_vertex(rand_coord(), rand_coord(), k == nverts - 1);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
